// ===== design/chm_pkg.sv =====
// Shared types and constants for the channel hop activity monitor.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package chm_pkg;

    localparam int CHAN_W = 7;
    localparam int HITS_W = 16;
    localparam int LVL_W  = 8;
    localparam int TMR_W  = 16;
    localparam int ELAP_W = 10;
    localparam int PKT_W  = 4;
    localparam int PROD_W = PKT_W + LVL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 96;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_PRESENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PKT_GAIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_STEP       = 3'd5;

    // Button action codes carried from front to back
    typedef logic [2:0] t_act;
    localparam t_act ACT_NONE  = 3'd0;
    localparam t_act ACT_DOWN  = 3'd1;
    localparam t_act ACT_UP    = 3'd2;
    localparam t_act ACT_RIGHT = 3'd3;
    localparam t_act ACT_LEFT  = 3'd4;

    typedef struct packed {
        logic              radio_present;
        logic [TMR_W-1:0]  dwell_ms;
        logic [TMR_W-1:0]  decay_period_ms;
        logic [TMR_W-1:0]  debounce_ms;
        logic [LVL_W-1:0]  pkt_gain;
        logic [LVL_W-1:0]  fade_step;
    } t_cfg;

    typedef struct packed {
        t_act              act;
        logic              hop;
        logic              decay;
        logic              credit;
        logic [PKT_W-1:0]  packets;
        logic [PROD_W-1:0] bump_prod;
    } t_cmd;

    function automatic logic [CHAN_W-1:0] reset_chan(input int idx);
        logic [CHAN_W-1:0] c;
        case (idx)
            0:       c = 7'd12;
            1:       c = 7'd37;
            2:       c = 7'd76;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/channel_hop_activity_monitor_core.sv =====
// Top level of the channel hop activity monitor: configuration registers,
// stream ports, and the front end / command queue / back end chain.
// Depends on chm_pkg, chm_front, chm_cmd_fifo and chm_back.
//
// Usage: each input beat on the s_axis channel is one pass of the monitor
// loop (elapsed time, four button levels, received packet count). Each
// pass yields exactly one result beat on m_axis with the tuned channel,
// hop flag, active and selected slot, selected channel and the per-slot
// hit counts and intensity levels after that pass.
// Each taken input beat passes through the command queue into the result register.
// Throughput: one beat per cycle while m_axis_tready stays high; the front end
// decides debounce, hop and decay from its own timers, so the two-entry command
// queue and the result register keep both sides running every cycle.
// When m_axis_tready is low the result holds, the back end stops draining
// the queue, and s_axis_tready drops once both queue entries are filled.
// Reset (i_rst_n low, synchronous) restores all registers to defaults:
// radio present, dwell 400, decay period 200, debounce 180, bump 50,
// decay 4, slot channels 12/37/76, button latch set, queue empty.
// Configuration writes via i_cfg_we/i_cfg_idx/i_cfg_wdata take effect at
// the next clock; write them only while no pass is in flight.
`timescale 1ns / 1ps

module channel_hop_activity_monitor_core #(
    parameter int NUM_SLOTS    = 3,
    parameter int NUM_CHANNELS = 126
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // elapsed_ms[9:0], key_up[10], key_down[11], key_left[12],
    // key_right[13], packets[17:14], zero pad[23:18]
    input  logic [chm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tuned_channel[6:0], retuned[7], active_slot[9:8], selected_slot[11:10],
    // selected_channel[18:12], hits_slot0[34:19], hits_slot1[50:35],
    // hits_slot2[66:51], level_slot0[74:67], level_slot1[82:75],
    // level_slot2[90:83], zero pad[95:91]
    output logic [chm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_we,
    input  logic [chm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [chm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import chm_pkg::*;

    t_cfg              r_cfg;
    t_cmd              w_front_cmd, w_q_cmd;
    logic              w_full, w_accept, w_q_valid, w_pop;
    logic [CHAN_W-1:0] w_tune, w_sel_chan;
    logic              w_retuned;
    logic [1:0]        w_act, w_sel;
    logic [HITS_W-1:0] w_hits  [3];
    logic [LVL_W-1:0]  w_level [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radio_present   <= 1'b1;
            r_cfg.dwell_ms        <= 16'd400;
            r_cfg.decay_period_ms <= 16'd200;
            r_cfg.debounce_ms     <= 16'd180;
            r_cfg.pkt_gain        <= 8'd50;
            r_cfg.fade_step       <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIO_PRESENT:   r_cfg.radio_present   <= i_cfg_wdata[0];
                CFG_DWELL_MS:        r_cfg.dwell_ms        <= i_cfg_wdata;
                CFG_DECAY_PERIOD_MS: r_cfg.decay_period_ms <= i_cfg_wdata;
                CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_wdata;
                CFG_PKT_GAIN:        r_cfg.pkt_gain        <= i_cfg_wdata[LVL_W-1:0];
                CFG_FADE_STEP:       r_cfg.fade_step       <= i_cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && !w_full;

    chm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (w_accept),
        .i_elapsed_ms (s_axis_tdata[9:0]),
        .i_key_up     (s_axis_tdata[10]),
        .i_key_down   (s_axis_tdata[11]),
        .i_key_left   (s_axis_tdata[12]),
        .i_key_right  (s_axis_tdata[13]),
        .i_packets    (s_axis_tdata[17:14]),
        .o_cmd        (w_front_cmd)
    );

    chm_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    chm_back #(
        .NUM_SLOTS    (NUM_SLOTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fade_step        (r_cfg.fade_step),
        .i_cmd_valid        (w_q_valid),
        .i_cmd              (w_q_cmd),
        .o_pop              (w_pop),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_tuned_channel    (w_tune),
        .o_retuned          (w_retuned),
        .o_active_slot      (w_act),
        .o_selected_slot    (w_sel),
        .o_selected_channel (w_sel_chan),
        .o_hits             (w_hits),
        .o_level            (w_level)
    );

    assign m_axis_tdata = {5'd0, w_level[2], w_level[1], w_level[0],
                           w_hits[2], w_hits[1], w_hits[0],
                           w_sel_chan, w_sel, w_act, w_retuned, w_tune};

endmodule

// ===== design/chm_front.sv =====
// Front end: accepts loop passes, runs the three timers and the button
// debounce, and turns each pass into one command. Depends on chm_pkg.
`timescale 1ns / 1ps

module chm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  chm_pkg::t_cfg             i_cfg,
    input  logic                      i_accept,
    input  logic [chm_pkg::ELAP_W-1:0] i_elapsed_ms,
    input  logic                      i_key_up,
    input  logic                      i_key_down,
    input  logic                      i_key_left,
    input  logic                      i_key_right,
    input  logic [chm_pkg::PKT_W-1:0] i_packets,
    output chm_pkg::t_cmd             o_cmd
);
    import chm_pkg::*;

    logic [TMR_W-1:0] r_since_hop, n_since_hop;
    logic [TMR_W-1:0] r_since_decay, n_since_decay;
    logic [TMR_W-1:0] r_since_press, n_since_press;
    logic             r_held, n_held;
    logic [TMR_W-1:0] w_hop_sat, w_decay_sat, w_press_sat;
    logic             w_any;

    function automatic logic [TMR_W-1:0] sat_add(input logic [TMR_W-1:0] a,
                                                 input logic [ELAP_W-1:0] b);
        logic [TMR_W:0] s;
        s = {1'b0, a} + (TMR_W+1)'(b);
        return s[TMR_W] ? {TMR_W{1'b1}} : s[TMR_W-1:0];
    endfunction

    assign w_hop_sat   = sat_add(r_since_hop, i_elapsed_ms);
    assign w_decay_sat = sat_add(r_since_decay, i_elapsed_ms);
    assign w_press_sat = sat_add(r_since_press, i_elapsed_ms);
    assign w_any = i_key_up | i_key_down | i_key_left | i_key_right;

    always_comb begin
        o_cmd         = '0;
        n_held        = r_held;
        n_since_press = w_press_sat;
        if (r_held) begin
            if (!w_any) n_held = 1'b0;
        end else if (w_any && (w_press_sat > i_cfg.debounce_ms)) begin
            if (i_key_down)       o_cmd.act = ACT_DOWN;
            else if (i_key_up)    o_cmd.act = ACT_UP;
            else if (i_key_right) o_cmd.act = ACT_RIGHT;
            else                  o_cmd.act = ACT_LEFT;
            n_since_press = '0;
            n_held        = 1'b1;
        end

        o_cmd.hop     = i_cfg.radio_present && (w_hop_sat >= i_cfg.dwell_ms);
        o_cmd.decay   = i_cfg.radio_present && (w_decay_sat >= i_cfg.decay_period_ms);
        o_cmd.credit  = i_cfg.radio_present;
        o_cmd.packets = i_packets;
        o_cmd.bump_prod = PROD_W'(i_packets) * PROD_W'(i_cfg.pkt_gain);

        // a step that fires drops any excess time
        n_since_hop   = o_cmd.hop ? '0 : w_hop_sat;
        n_since_decay = o_cmd.decay ? '0 : w_decay_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_hop   <= '0;
            r_since_decay <= '0;
            r_since_press <= {TMR_W{1'b1}};
            r_held        <= 1'b1;
        end else if (i_accept) begin
            r_since_hop   <= n_since_hop;
            r_since_decay <= n_since_decay;
            r_since_press <= n_since_press;
            r_held        <= n_held;
        end
    end

`ifndef NO_ASSERTIONS
    // an action always restarts the debounce gap and sets the latch
    a_action_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (o_cmd.act != ACT_NONE) |=> r_held && (r_since_press == '0))
        else $error("button action did not latch");
    // no button action is produced while the latch is held
    a_held_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (o_cmd.act == ACT_NONE))
        else $error("button acted while latch held");
    // steps never fire with the radio absent
    a_radio_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.radio_present |-> !o_cmd.hop && !o_cmd.decay && !o_cmd.credit)
        else $error("radio step fired while radio absent");
`endif

endmodule

// ===== design/chm_cmd_fifo.sv =====
// Two-entry command queue between front and back ends.
// Depends on chm_pkg for the command type.
`timescale 1ns / 1ps

module chm_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  chm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output chm_pkg::t_cmd o_cmd
);
    import chm_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== design/chm_back.sv =====
// Back end: applies commands to slot channels, selection, hop state,
// hit counts and intensities; its state registers are the result beat.
// Depends on chm_pkg.
`timescale 1ns / 1ps

module chm_back #(
    parameter int NUM_SLOTS    = 3,
    parameter int NUM_CHANNELS = 126
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [chm_pkg::LVL_W-1:0]   i_fade_step,
    input  logic                        i_cmd_valid,
    input  chm_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [chm_pkg::CHAN_W-1:0]  o_tuned_channel,
    output logic                        o_retuned,
    output logic [1:0]                  o_active_slot,
    output logic [1:0]                  o_selected_slot,
    output logic [chm_pkg::CHAN_W-1:0]  o_selected_channel,
    output logic [chm_pkg::HITS_W-1:0]  o_hits [3],
    output logic [chm_pkg::LVL_W-1:0]   o_level [3]
);
    import chm_pkg::*;

    localparam int SW    = $clog2(NUM_SLOTS);
    localparam int SHOWN = (NUM_SLOTS < 3) ? NUM_SLOTS : 3;
    localparam logic [SW-1:0]     LAST_SLOT = SW'(NUM_SLOTS - 1);
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS - 1);

    logic [CHAN_W-1:0] w_rst_chan [NUM_SLOTS];

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_rst
        localparam logic [CHAN_W-1:0] RST = CHAN_W'(32'(reset_chan(g)) % NUM_CHANNELS);
        assign w_rst_chan[g] = RST;
    end

    // two copies of the channel table: one read for the cursor, one for the hop
    logic [CHAN_W-1:0] r_chan_a [NUM_SLOTS];
    logic [CHAN_W-1:0] r_chan_b [NUM_SLOTS];
    logic [HITS_W-1:0] r_hits   [NUM_SLOTS];
    logic [LVL_W-1:0]  r_level  [NUM_SLOTS];
    logic [SW-1:0]     r_sel, n_sel, r_act, n_act;
    logic [CHAN_W-1:0] r_sel_chan, n_sel_chan, r_tune, n_tune;
    logic              r_retuned, r_valid;
    logic              w_move, w_edit;
    logic [CHAN_W-1:0] w_edit_val;

    assign o_pop = i_cmd_valid && (!r_valid || i_ready);

    always_comb begin
        w_move     = 1'b0;
        w_edit     = 1'b0;
        w_edit_val = r_sel_chan;
        n_sel      = r_sel;
        unique case (i_cmd.act)
            ACT_NONE: ;
            ACT_DOWN: begin
                w_move = 1'b1;
                n_sel  = (r_sel == LAST_SLOT) ? '0 : r_sel + SW'(1);
            end
            ACT_UP: begin
                w_move = 1'b1;
                n_sel  = (r_sel == '0) ? LAST_SLOT : r_sel - SW'(1);
            end
            ACT_RIGHT: begin
                w_edit     = 1'b1;
                w_edit_val = (r_sel_chan == LAST_CHAN) ? '0 : r_sel_chan + CHAN_W'(1);
            end
            ACT_LEFT: begin
                w_edit     = 1'b1;
                w_edit_val = (r_sel_chan == '0) ? LAST_CHAN : r_sel_chan - CHAN_W'(1);
            end
            default: ;
        endcase

        if (w_edit)      n_sel_chan = w_edit_val;
        else if (w_move) n_sel_chan = r_chan_a[n_sel];
        else             n_sel_chan = r_sel_chan;

        n_act  = r_act;
        n_tune = r_tune;
        if (i_cmd.hop) begin
            n_act  = (r_act == LAST_SLOT) ? '0 : r_act + SW'(1);
            // an edit in this pass of the slot hopped to is already visible
            n_tune = (w_edit && (r_sel == n_act)) ? w_edit_val : r_chan_b[n_act];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_retuned  <= 1'b0;
            r_sel      <= '0;
            r_act      <= '0;
            r_sel_chan <= w_rst_chan[0];
            r_tune     <= w_rst_chan[0];
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_chan_a[i] <= w_rst_chan[i];
                r_chan_b[i] <= w_rst_chan[i];
                r_hits[i]   <= '0;
                r_level[i]  <= '0;
            end
        end else begin
            if (o_pop)        r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (o_pop) begin
                r_retuned  <= i_cmd.hop;
                r_sel      <= n_sel;
                r_act      <= n_act;
                r_sel_chan <= n_sel_chan;
                r_tune     <= n_tune;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    logic [LVL_W+PROD_W-1:0] v;
                    logic [LVL_W-1:0]        lv;
                    logic                    hit;
                    hit = i_cmd.credit && (n_act == SW'(i));
                    if (w_edit && (r_sel == SW'(i))) begin
                        r_chan_a[i] <= w_edit_val;
                        r_chan_b[i] <= w_edit_val;
                    end
                    if (hit) r_hits[i] <= r_hits[i] + HITS_W'(i_cmd.packets);
                    v  = (LVL_W+PROD_W)'(r_level[i]) +
                         (hit ? (LVL_W+PROD_W)'(i_cmd.bump_prod) : '0);
                    lv = (v > (LVL_W+PROD_W)'(255)) ? 8'd255 : v[LVL_W-1:0];
                    if (i_cmd.decay)
                        lv = (lv >= i_fade_step) ? lv - i_fade_step : '0;
                    r_level[i] <= lv;
                end
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_tuned_channel    = r_tune;
    assign o_retuned          = r_retuned;
    assign o_active_slot      = 2'(r_act);
    assign o_selected_slot    = 2'(r_sel);
    assign o_selected_channel = r_sel_chan;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            o_hits[j]  = '0;
            o_level[j] = '0;
        end
        for (int j = 0; j < SHOWN; j++) begin
            o_hits[j]  = r_hits[j];
            o_level[j] = r_level[j];
        end
    end

`ifndef NO_ASSERTIONS
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_sel) < NUM_SLOTS) && (32'(r_act) < NUM_SLOTS))
        else $error("slot index out of range");
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_tune) < NUM_CHANNELS) && (32'(r_sel_chan) < NUM_CHANNELS))
        else $error("channel out of range");
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sel_chan == r_chan_a[r_sel]) && (r_chan_a[r_sel] == r_chan_b[r_sel]))
        else $error("channel table copies disagree");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_tune) && $stable(r_sel) && $stable(r_act))
        else $error("result changed while stalled");
`endif

endmodule

// ===== tb/channel_hop_activity_monitor_core_tb.sv =====
// Self-checking testbench for channel_hop_activity_monitor_core.
// Holds a scoreboard class that predicts each pass result, plus stream and config drivers.
// Depends on chm_pkg and the core RTL only.
`timescale 1ns / 1ps

module channel_hop_activity_monitor_core_tb;

    localparam int NSLOT = 3;
    localparam int NCHAN = 126;
    localparam logic [chm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;

    // One pass beat, lowest field last
    typedef struct packed {
        logic [5:0] pad;
        logic [3:0] packets;
        logic       right;
        logic       left;
        logic       down;
        logic       up;
        logic [9:0] elapsed;
    } pass_t;

    // One result beat, lowest field last
    typedef struct packed {
        logic [4:0]  pad;
        logic [7:0]  lvl2;
        logic [7:0]  lvl1;
        logic [7:0]  lvl0;
        logic [15:0] hits2;
        logic [15:0] hits1;
        logic [15:0] hits0;
        logic [6:0]  sel_chan;
        logic [1:0]  sel_slot;
        logic [1:0]  act_slot;
        logic        retuned;
        logic [6:0]  tune;
    } snapshot_t;

    typedef enum int {GEN_MIXED, GEN_SLOW, GEN_ROLLOVER} gen_t;

    class hop_scoreboard;
        bit        radio_on;
        bit [15:0] dwell;
        bit [15:0] decay_period;
        bit [15:0] debounce;
        bit [7:0]  bump;
        bit [7:0]  decay_step;

        bit [6:0]  slot_chan [NSLOT];
        bit [15:0] hits [NSLOT];
        bit [7:0]  level [NSLOT];
        bit [1:0]  cursor;
        bit [1:0]  live_slot;
        bit [6:0]  tune;
        bit [15:0] t_hop;
        bit [15:0] t_decay;
        bit [15:0] t_press;
        bit        latch;

        snapshot_t snapshot_q [$];
        int        mismatches;

        function new();
            radio_on     = 1'b1;
            dwell        = 16'd400;
            decay_period = 16'd200;
            debounce     = 16'd180;
            bump         = 8'd50;
            decay_step   = 8'd4;
            slot_chan[0] = 7'd12;
            slot_chan[1] = 7'd37;
            slot_chan[2] = 7'd76;
            foreach (hits[i]) begin
                hits[i]  = '0;
                level[i] = '0;
            end
            cursor     = '0;
            live_slot  = '0;
            tune       = slot_chan[0];
            t_hop      = '0;
            t_decay    = '0;
            t_press    = 16'hFFFF;
            latch      = 1'b1;
            mismatches = 0;
        endfunction

        function bit [15:0] sat16(int unsigned v);
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        function void write_reg(logic [chm_pkg::CFG_IDX_W-1:0] idx,
                                logic [chm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                chm_pkg::CFG_RADIO_PRESENT:   radio_on     = data[0];
                chm_pkg::CFG_DWELL_MS:        dwell        = data;
                chm_pkg::CFG_DECAY_PERIOD_MS: decay_period = data;
                chm_pkg::CFG_DEBOUNCE_MS:     debounce     = data;
                chm_pkg::CFG_PKT_GAIN:        bump         = data[7:0];
                chm_pkg::CFG_FADE_STEP:       decay_step   = data[7:0];
                default: ;
            endcase
        endfunction

        // Advance the state by one pass and queue the result it must produce
        function void take_pass(pass_t p);
            snapshot_t     s;
            chm_pkg::t_act action;
            bit [6:0]      c;
            bit            any_btn;
            bit            hopped;
            int unsigned   sum;
            hopped  = 1'b0;
            any_btn = p.up | p.down | p.left | p.right;
            t_hop   = sat16(32'(t_hop) + 32'(p.elapsed));
            t_decay = sat16(32'(t_decay) + 32'(p.elapsed));
            t_press = sat16(32'(t_press) + 32'(p.elapsed));

            if (latch) begin
                if (!any_btn)
                    latch = 1'b0;
            end else if (any_btn && t_press > debounce) begin
                action = p.down ? chm_pkg::ACT_DOWN :
                         p.up   ? chm_pkg::ACT_UP :
                         p.right ? chm_pkg::ACT_RIGHT : chm_pkg::ACT_LEFT;
                c = slot_chan[cursor];
                case (action)
                    chm_pkg::ACT_DOWN:  cursor = (cursor == NSLOT - 1) ? 2'd0 : cursor + 2'd1;
                    chm_pkg::ACT_UP:    cursor = (cursor == 0) ? 2'(NSLOT - 1) : cursor - 2'd1;
                    chm_pkg::ACT_RIGHT: slot_chan[cursor] = (c == NCHAN - 1) ? 7'd0 : c + 7'd1;
                    default:            slot_chan[cursor] = (c == 0) ? 7'(NCHAN - 1) : c - 7'd1;
                endcase
                t_press = '0;
                latch   = 1'b1;
            end

            if (radio_on) begin
                if (t_hop >= dwell) begin
                    live_slot = (live_slot == NSLOT - 1) ? 2'd0 : live_slot + 2'd1;
                    tune      = slot_chan[live_slot];
                    t_hop     = '0;
                    hopped    = 1'b1;
                end
                hits[live_slot] = hits[live_slot] + 16'(p.packets);
                sum = 32'(level[live_slot]) + 32'(p.packets) * 32'(bump);
                level[live_slot] = (sum > 255) ? 8'd255 : sum[7:0];
                if (t_decay >= decay_period) begin
                    foreach (level[i])
                        level[i] = (level[i] >= decay_step) ? level[i] - decay_step : 8'd0;
                    t_decay = '0;
                end
            end

            s          = '0;
            s.tune     = tune;
            s.retuned  = hopped;
            s.act_slot = live_slot;
            s.sel_slot = cursor;
            s.sel_chan = slot_chan[cursor];
            s.hits0    = hits[0];
            s.hits1    = hits[1];
            s.hits2    = hits[2];
            s.lvl0     = level[0];
            s.lvl1     = level[1];
            s.lvl2     = level[2];
            snapshot_q.push_back(s);
        endfunction

        function void same(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_snapshot(snapshot_t g);
            snapshot_t e;
            if (snapshot_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h", $time, g);
                mismatches++;
                return;
            end
            e = snapshot_q.pop_front();
            same("tuned_channel", e.tune, g.tune);
            same("retuned", e.retuned, g.retuned);
            same("active_slot", e.act_slot, g.act_slot);
            same("selected_slot", e.sel_slot, g.sel_slot);
            same("selected_channel", e.sel_chan, g.sel_chan);
            same("hits_slot0", e.hits0, g.hits0);
            same("hits_slot1", e.hits1, g.hits1);
            same("hits_slot2", e.hits2, g.hits2);
            same("level_slot0", e.lvl0, g.lvl0);
            same("level_slot1", e.lvl1, g.lvl1);
            same("level_slot2", e.lvl2, g.lvl2);
            same("pad", e.pad, g.pad);
        endfunction

        function int pending();
            return snapshot_q.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic [chm_pkg::IN_TDATA_W-1:0]      s_axis_tdata = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [chm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [chm_pkg::CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [chm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata = '0;

    int snd_idle_pct = 0;
    int rcv_stall_pct = 0;

    hop_scoreboard sb = new();

    channel_hop_activity_monitor_core #(
        .NUM_SLOTS    (NSLOT),
        .NUM_CHANNELS (NCHAN)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_snapshot(m_axis_tdata);
    end

    function automatic pass_t mk(int el, bit up, bit down, bit left, bit right, int pk);
        pass_t p;
        p         = '0;
        p.elapsed = 10'(el);
        p.up      = up;
        p.down    = down;
        p.left    = left;
        p.right   = right;
        p.packets = 4'(pk);
        return p;
    endfunction

    function automatic pass_t random_pass(gen_t mode);
        pass_t p;
        int    r;
        p = '0;
        r = $urandom_range(0, 99);
        if (mode == GEN_ROLLOVER) begin
            // keep the hit counter of one slot climbing fast
            p.elapsed = 10'($urandom_range(0, 3));
            p.packets = (r < 5) ? 4'($urandom_range(0, 15)) : 4'd15;
            if ($urandom_range(0, 99) < 5)
                {p.right, p.left, p.down, p.up} = 4'b0001 << $urandom_range(0, 3);
            return p;
        end
        if (mode == GEN_SLOW)
            p.elapsed = (r < 50) ? 10'd1023 : 10'($urandom_range(0, 1023));
        else if (r < 35)
            p.elapsed = 10'($urandom_range(0, 50));
        else if (r < 75)
            p.elapsed = 10'($urandom_range(0, 300));
        else if (r < 95)
            p.elapsed = 10'($urandom_range(0, 1023));
        else
            p.elapsed = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        r = $urandom_range(0, 99);
        if (r >= 55 && r < 85)
            {p.right, p.left, p.down, p.up} = 4'b0001 << $urandom_range(0, 3);
        else if (r >= 85)
            {p.right, p.left, p.down, p.up} = 4'($urandom_range(0, 15));
        p.packets = ($urandom_range(0, 99) < 30) ? 4'd0 : 4'($urandom_range(0, 15));
        return p;
    endfunction

    task automatic send_pass(pass_t p);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_pass(p);
    endtask

    // Hold off the sender until every result is back, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [chm_pkg::CFG_IDX_W-1:0] idx,
                             logic [chm_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic run_phase(int n, gen_t mode, bit radio, int dwell, int decay_p,
                             int debounce, int bump, int decay_step,
                             int snd, int rcv, bit mid_pause);
        int    sent;
        int    k;
        int    btn;
        int    press_el;
        bit    paused;
        pass_t p;
        drain();
        // narrow registers get junk in the upper bits to check masking
        cfg_write(chm_pkg::CFG_RADIO_PRESENT, {15'($urandom_range(0, 32767)), radio});
        cfg_write(chm_pkg::CFG_DWELL_MS, 16'(dwell));
        cfg_write(chm_pkg::CFG_DECAY_PERIOD_MS, 16'(decay_p));
        cfg_write(chm_pkg::CFG_DEBOUNCE_MS, 16'(debounce));
        cfg_write(chm_pkg::CFG_PKT_GAIN, {8'($urandom_range(0, 255)), 8'(bump)});
        cfg_write(chm_pkg::CFG_FADE_STEP, {8'($urandom_range(0, 255)), 8'(decay_step)});
        cfg_write(CFG_IDX_SPARE + 3'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        sent   = 0;
        paused = 1'b0;
        while (sent < n) begin
            if (mid_pause && !paused && sent >= n / 2) begin
                drain();
                paused = 1'b1;
            end
            if (mode == GEN_MIXED && $urandom_range(0, 99) < 6) begin
                // run of clean press/release pairs on one button
                btn      = $urandom_range(0, 3);
                k        = $urandom_range(2, 40);
                press_el = (debounce >= 1022) ? 1023 : debounce + 1 + $urandom_range(0, 30);
                if (press_el > 1023)
                    press_el = 1023;
                repeat (k) begin
                    send_pass(mk(press_el, btn == 1, btn == 0, btn == 3, btn == 2,
                                 $urandom_range(0, 15)));
                    send_pass(mk($urandom_range(0, 10), 0, 0, 0, 0, $urandom_range(0, 15)));
                    sent += 2;
                end
            end else begin
                p = random_pass(mode);
                send_pass(p);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed passes at reset settings
        send_pass(mk(0, 1, 1, 1, 1, 0));      // press while latched after reset
        send_pass(mk(0, 0, 0, 0, 0, 0));      // release clears latch
        send_pass(mk(181, 0, 1, 0, 0, 3));
        send_pass(mk(10, 0, 1, 0, 0, 0));     // still held
        send_pass(mk(10, 0, 0, 0, 0, 0));
        send_pass(mk(20, 1, 0, 0, 0, 15));    // too early, level saturates
        send_pass(mk(200, 1, 0, 0, 0, 0));
        send_pass(mk(0, 0, 0, 0, 0, 0));
        send_pass(mk(1023, 1, 1, 1, 1, 15));  // all pressed: down wins
        send_pass(mk(0, 0, 0, 0, 0, 0));
        send_pass(mk(1023, 1, 0, 1, 1, 0));   // up over right and left
        send_pass(mk(0, 0, 0, 0, 0, 0));
        send_pass(mk(1023, 0, 0, 1, 1, 7));   // right over left
        send_pass(mk(0, 0, 0, 0, 0, 0));
        send_pass(mk(1023, 0, 0, 1, 0, 1));
        send_pass(mk(0, 0, 0, 0, 0, 0));
        send_pass(mk(181, 0, 0, 0, 1, 8));
        send_pass(mk(0, 0, 0, 0, 0, 0));
        send_pass(mk(180, 0, 0, 1, 0, 0));    // exactly at debounce: ignored
        send_pass(mk(1, 0, 0, 1, 0, 0));
        send_pass(mk(399, 0, 0, 0, 0, 0));
        send_pass(mk(1023, 0, 0, 0, 0, 15));

        run_phase(200, GEN_MIXED, 1, 400, 200, 180, 50, 4, 0, 0, 0);
        run_phase(200, GEN_MIXED, 1, 1, 1, 0, 255, 255, 74, 0, 0);
        run_phase(150, GEN_MIXED, 1, 0, 0, 65535, 0, 0, 0, 74, 0);
        // radio off with long gaps: hop and decay timers saturate
        run_phase(150, GEN_SLOW, 0, 65535, 65535, 50, 17, 9, 9, 9, 0);
        run_phase(200, GEN_MIXED, 1, 700, 150, 50, 17, 9, 0, 0, 1);
        run_phase(250, GEN_MIXED, 1, $urandom_range(1, 2000), $urandom_range(1, 1000),
                  $urandom_range(0, 400), $urandom_range(0, 255), $urandom_range(0, 255),
                  74, 0, 0);
        run_phase(250, GEN_MIXED, 1, $urandom_range(1, 2000), $urandom_range(1, 1000),
                  $urandom_range(0, 400), $urandom_range(0, 255), $urandom_range(0, 255),
                  0, 74, 0);
        run_phase(250, GEN_MIXED, 1, $urandom_range(1, 2000), $urandom_range(1, 1000),
                  $urandom_range(0, 400), $urandom_range(0, 255), $urandom_range(0, 255),
                  9, 9, 0);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== channel_hop_activity_monitor_core.f =====
design/chm_pkg.sv
design/chm_front.sv
design/chm_cmd_fifo.sv
design/chm_back.sv
design/channel_hop_activity_monitor_core.sv
tb/channel_hop_activity_monitor_core_tb.sv
